/* rtl/pfmc_pkg.sv */
// ============================================================================
// Page frame manager package
// Shared types, codes and command/status bundles of the page frame manager.
// ============================================================================
package pfmc_pkg;

   localparam int CFG_W   = 11;
   localparam int RUN_W   = 11;
   localparam int OWNER_W = 32;
   localparam int FRAME_W = 10;

   // Request modes.
   localparam logic [2:0] MODE_INIT  = 3'd0;
   localparam logic [2:0] MODE_ALLOC = 3'd1;
   localparam logic [2:0] MODE_FREE  = 3'd2;
   localparam logic [2:0] MODE_REF   = 3'd3;
   localparam logic [2:0] MODE_EVICT = 3'd4;

   // Response status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NO_SPACE  = 3'd1;
   localparam logic [2:0] STAT_BAD_FREE  = 3'd2;
   localparam logic [2:0] STAT_NO_VICTIM = 3'd3;
   localparam logic [2:0] STAT_BAD_REF   = 3'd4;

   // Frame kinds.
   localparam logic [1:0] KIND_FREE = 2'd0;
   localparam logic [1:0] KIND_KERN = 2'd1;
   localparam logic [1:0] KIND_USER = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_FIRST_USABLE = 1'b0;
   localparam logic CSR_FRAME_LIMIT  = 1'b1;

   typedef struct packed {
      logic [2:0]         mode;
      logic [RUN_W-1:0]   page_count;
      logic               kernel_alloc;
      logic [OWNER_W-1:0] owner_tag;
      logic [FRAME_W-1:0] frame;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [FRAME_W-1:0] result_frame;
      logic [OWNER_W-1:0] result_owner;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [RUN_W-1:0]   run;
      logic [OWNER_W-1:0] owner;
   } entry_type;

   typedef enum logic [2:0] {
      LD_NONE, LD_INIT, LD_SCAN_F, LD_FR, LD_HAND, LD_RUN, LD_ALLOC_WR, LD_REWIND
   } load_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_CLEAR, WR_INIT, WR_ALLOC, WR_FREE, WR_REF_SET, WR_REF_CLR
   } wr_type;

   typedef enum logic [1:0] {
      RS_ZERO, RS_START, RS_FR, RS_VICTIM
   } rsel_type;

   typedef struct packed {
      logic       latch;
      load_type   ld;
      logic       rd_en;
      wr_type     wr;
      logic       cnt_upd;
      logic       hand_load;
      logic       hand_clear;
      logic       rsp_fire;
      logic [2:0] rsp_status;
      rsel_type   rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       pv;
      logic       idx_more;
      logic       wr_last;
      logic       d_free;
      logic       d_user;
      logic       d_ref;
      logic       owner_zero;
      logic       cnt_hit;
      logic       n_zero;
      logic       fr_in_range;
      logic       fr_below_l;
      logic       run_bad;
   } stat_type;

endpackage

/* rtl/page_frame_manager_clock_unit.sv */
// ============================================================================
// Page frame manager with clock replacement
// First-fit run allocator over a physical frame map with second-chance
// victim selection.
// ============================================================================
//
//  Channel   Ports                                 Direction   Handshake
//  request   start, busy, req_data                 in          start & !busy
//  response  rsp_valid, rsp_data                   out         one-cycle strobe
//  config    csr_valid, csr_ready, csr_index,      in          valid & ready
//            csr_wdata
//
// Each transaction walks the frame map one entry per cycle. Allocate scans
// for a free run and then writes it; free reads its run, checks it and then
// writes it; evict walks from the clock hand to the limit and, if needed,
// once more from the first usable frame; init writes every frame. The
// single-port frame map sets the pace. After reset a clearing pass over every frame holds busy high.
// Each response is strobed for one cycle; the receiver cannot stall it.
//
module page_frame_manager_clock_unit #(
   parameter int FRAMES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  pfmc_pkg::req_type           req_data,
   output logic                        rsp_valid,
   output pfmc_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [pfmc_pkg::CFG_W-1:0]  csr_wdata
);

   // Configuration registers; the effective limits are derived in the
   // datapath by clamping against the frame count.
   logic [pfmc_pkg::CFG_W-1:0] first_ff, first_in;
   logic [pfmc_pkg::CFG_W-1:0] limit_ff, limit_in;

   pfmc_pkg::cmd_type  cmd;
   pfmc_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   always_comb begin
      first_in = first_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            pfmc_pkg::CSR_FIRST_USABLE: first_in = csr_wdata;
            pfmc_pkg::CSR_FRAME_LIMIT:  limit_in = csr_wdata;
            default:                    first_in = first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         limit_ff <= pfmc_pkg::CFG_W'(1024);
      end else begin
         first_ff <= first_in;
         limit_ff <= limit_in;
      end
   end

   // The controller sequences the walks; the datapath owns the frame map.
   pfmc_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pfmc_datapath #(
      .FRAMES (FRAMES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_data),
      .first_cfg (first_ff),
      .limit_cfg (limit_ff),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/pfmc_datapath.sv */
// ============================================================================
// Page frame manager datapath
// Frame map memories, walk counters, clock hand and the response register.
// ============================================================================
module pfmc_datapath #(
   parameter int FRAMES = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pfmc_pkg::req_type         req_in,
   input  logic [pfmc_pkg::CFG_W-1:0] first_cfg,
   input  logic [pfmc_pkg::CFG_W-1:0] limit_cfg,
   input  pfmc_pkg::cmd_type         cmd,
   output pfmc_pkg::stat_type        stat,
   output logic                      rsp_valid,
   output pfmc_pkg::rsp_type         rsp_data
);

   localparam int FW = $clog2(FRAMES);
   localparam int IW = $clog2(FRAMES + 1);
   localparam int AW = (IW > pfmc_pkg::CFG_W) ? IW : pfmc_pkg::CFG_W;

   pfmc_pkg::entry_type entry_mem [FRAMES];
   logic                ref_mem   [FRAMES];

   pfmc_pkg::req_type   req_ff;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       end_ff, end_in;
   logic [AW-1:0]       start_ff, start_in;
   logic [AW-1:0]       pidx_ff, pidx_in;
   logic                pv_ff, pv_in;
   logic [pfmc_pkg::RUN_W-1:0] cnt_ff, cnt_in;
   logic [FW-1:0]       hand_ff, hand_in;
   pfmc_pkg::entry_type rd_ff;
   logic                rref_ff;
   logic                rsp_valid_ff;
   pfmc_pkg::rsp_type   rsp_ff, rsp_in;

   logic [AW-1:0]       lim, first, frx, nx, alloc_start;
   logic                rd_fire, wr_pass, mem_we, ref_we, ref_wd;
   logic [FW-1:0]       waddr;
   pfmc_pkg::entry_type wdata;

   assign lim   = (AW'(limit_cfg) < AW'(FRAMES)) ? AW'(limit_cfg) : AW'(FRAMES);
   assign first = (AW'(first_cfg) < lim) ? AW'(first_cfg) : lim;
   assign frx   = AW'(req_ff.frame);
   assign nx    = AW'(req_ff.page_count);
   assign alloc_start = pidx_ff + AW'(1) - nx;

   assign rd_fire = cmd.rd_en && (cmd.ld == pfmc_pkg::LD_NONE) && (idx_ff < end_ff);
   assign wr_pass = (cmd.wr == pfmc_pkg::WR_CLEAR) || (cmd.wr == pfmc_pkg::WR_INIT) ||
                    (cmd.wr == pfmc_pkg::WR_ALLOC) || (cmd.wr == pfmc_pkg::WR_FREE);

   // Walk registers.
   always_comb begin
      idx_in   = idx_ff;
      end_in   = end_ff;
      start_in = start_ff;
      pv_in    = rd_fire;
      pidx_in  = rd_fire ? idx_ff : pidx_ff;
      cnt_in   = cnt_ff;
      case (cmd.ld)
         pfmc_pkg::LD_INIT: begin
            idx_in = '0;
            end_in = AW'(FRAMES);
         end
         pfmc_pkg::LD_SCAN_F: begin
            idx_in = first;
            end_in = lim;
         end
         pfmc_pkg::LD_FR: begin
            idx_in = frx;
            end_in = lim;
         end
         pfmc_pkg::LD_HAND: begin
            idx_in = AW'(hand_ff) + AW'(1);
            end_in = lim;
         end
         pfmc_pkg::LD_RUN: begin
            idx_in   = frx;
            start_in = frx;
            end_in   = frx + AW'(rd_ff.run);
         end
         pfmc_pkg::LD_ALLOC_WR: begin
            idx_in   = alloc_start;
            start_in = alloc_start;
            end_in   = pidx_ff + AW'(1);
         end
         pfmc_pkg::LD_REWIND: begin
            idx_in = start_ff;
         end
         default: begin
            if (rd_fire || wr_pass) begin
               idx_in = idx_ff + AW'(1);
            end
         end
      endcase
      if (cmd.ld != pfmc_pkg::LD_NONE) begin
         cnt_in = '0;
      end else if (cmd.cnt_upd) begin
         cnt_in = (rd_ff.kind == pfmc_pkg::KIND_FREE) ? cnt_ff + 1'b1 : '0;
      end
   end

   always_comb begin
      hand_in = hand_ff;
      if (cmd.hand_clear) begin
         hand_in = '0;
      end else if (cmd.hand_load) begin
         hand_in = pidx_ff[FW-1:0];
      end
   end

   // Write port: pass writes go to the walk index, reference updates to the
   // entry that was just examined.
   always_comb begin
      mem_we = 1'b0;
      ref_we = 1'b0;
      ref_wd = 1'b0;
      wdata  = '0;
      waddr  = idx_ff[FW-1:0];
      case (cmd.wr)
         pfmc_pkg::WR_CLEAR: begin
            mem_we    = 1'b1;
            ref_we    = 1'b1;
            wdata.kind = pfmc_pkg::KIND_FREE;
            wdata.run  = pfmc_pkg::RUN_W'(1);
         end
         pfmc_pkg::WR_INIT: begin
            mem_we     = 1'b1;
            ref_we     = 1'b1;
            ref_wd     = idx_ff < first;
            wdata.kind = (idx_ff < first) ? pfmc_pkg::KIND_KERN : pfmc_pkg::KIND_FREE;
            wdata.run  = pfmc_pkg::RUN_W'(1);
         end
         pfmc_pkg::WR_ALLOC: begin
            mem_we      = 1'b1;
            wdata.kind  = req_ff.kernel_alloc ? pfmc_pkg::KIND_KERN : pfmc_pkg::KIND_USER;
            wdata.run   = (idx_ff == start_ff) ? req_ff.page_count : '0;
            wdata.owner = req_ff.kernel_alloc ? '0 : req_ff.owner_tag;
         end
         pfmc_pkg::WR_FREE: begin
            mem_we     = 1'b1;
            ref_we     = 1'b1;
            ref_wd     = 1'b1;
            wdata.kind = pfmc_pkg::KIND_FREE;
         end
         pfmc_pkg::WR_REF_SET: begin
            ref_we = 1'b1;
            ref_wd = 1'b1;
            waddr  = pidx_ff[FW-1:0];
         end
         pfmc_pkg::WR_REF_CLR: begin
            ref_we = 1'b1;
            waddr  = pidx_ff[FW-1:0];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_fire) begin
         rd_ff   <= entry_mem[idx_ff[FW-1:0]];
         rref_ff <= ref_mem[idx_ff[FW-1:0]];
      end
      if (mem_we) begin
         entry_mem[waddr] <= wdata;
      end
      if (ref_we) begin
         ref_mem[waddr] <= ref_wd;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_fire) begin
         rsp_in.status       = cmd.rsp_status;
         rsp_in.result_owner = '0;
         case (cmd.rsp_sel)
            pfmc_pkg::RS_START:  rsp_in.result_frame = start_ff[pfmc_pkg::FRAME_W-1:0];
            pfmc_pkg::RS_FR:     rsp_in.result_frame = req_ff.frame;
            pfmc_pkg::RS_VICTIM: begin
               rsp_in.result_frame = pidx_ff[pfmc_pkg::FRAME_W-1:0];
               rsp_in.result_owner = rd_ff.owner;
            end
            default:             rsp_in.result_frame = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         end_ff       <= AW'(FRAMES);
         pv_ff        <= 1'b0;
         cnt_ff       <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         end_ff       <= end_in;
         pv_ff        <= pv_in;
         cnt_ff       <= cnt_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= cmd.rsp_fire;
      end
      start_ff <= start_in;
      pidx_ff  <= pidx_in;
      rsp_ff   <= rsp_in;
      if (cmd.latch) begin
         req_ff <= req_in;
      end
   end

   assign stat.mode        = req_ff.mode;
   assign stat.pv          = pv_ff;
   assign stat.idx_more    = idx_ff < end_ff;
   assign stat.wr_last     = (idx_ff + AW'(1)) == end_ff;
   assign stat.d_free      = rd_ff.kind == pfmc_pkg::KIND_FREE;
   assign stat.d_user      = rd_ff.kind == pfmc_pkg::KIND_USER;
   assign stat.d_ref       = rref_ff;
   assign stat.owner_zero  = rd_ff.owner == '0;
   assign stat.cnt_hit     = (rd_ff.kind == pfmc_pkg::KIND_FREE) &&
                             ((12'(cnt_ff) + 12'd1) == 12'(req_ff.page_count));
   assign stat.n_zero      = req_ff.page_count == '0;
   assign stat.fr_in_range = (frx >= first) && (frx < lim);
   assign stat.fr_below_l  = frx < lim;
   assign stat.run_bad     = (rd_ff.run == '0) || (AW'(rd_ff.run) > (lim - frx));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/pfmc_controller.sv */
// ============================================================================
// Page frame manager controller
// Sequences the clearing pass and every request over the frame map walks.
// ============================================================================
module pfmc_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pfmc_pkg::stat_type stat,
   output pfmc_pkg::cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_CLEAR    = 14'b00000000000001,
      S_IDLE     = 14'b00000000000010,
      S_DISPATCH = 14'b00000000000100,
      S_INIT     = 14'b00000000001000,
      S_ASCAN    = 14'b00000000010000,
      S_AWRITE   = 14'b00000000100000,
      S_FHEAD    = 14'b00000001000000,
      S_FRUN     = 14'b00000010000000,
      S_FCHECK   = 14'b00000100000000,
      S_FWRITE   = 14'b00001000000000,
      S_RREAD    = 14'b00010000000000,
      S_REVAL    = 14'b00100000000000,
      S_ESCAN1   = 14'b01000000000000,
      S_ESCAN2   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr = pfmc_pkg::WR_CLEAR;
            if (stat.wr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               pfmc_pkg::MODE_INIT: begin
                  cmd.ld         = pfmc_pkg::LD_INIT;
                  cmd.hand_clear = 1'b1;
                  state_in       = S_INIT;
               end
               pfmc_pkg::MODE_ALLOC: begin
                  if (stat.n_zero) begin
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = pfmc_pkg::STAT_NO_SPACE;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ld   = pfmc_pkg::LD_SCAN_F;
                     state_in = S_ASCAN;
                  end
               end
               pfmc_pkg::MODE_FREE: begin
                  if (!stat.fr_in_range) begin
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = pfmc_pkg::STAT_BAD_FREE;
                     cmd.rsp_sel    = pfmc_pkg::RS_FR;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ld   = pfmc_pkg::LD_FR;
                     state_in = S_FHEAD;
                  end
               end
               pfmc_pkg::MODE_REF: begin
                  if (!stat.fr_below_l) begin
                     cmd.rsp_fire   = 1'b1;
                     cmd.rsp_status = pfmc_pkg::STAT_BAD_REF;
                     cmd.rsp_sel    = pfmc_pkg::RS_FR;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.ld   = pfmc_pkg::LD_FR;
                     state_in = S_RREAD;
                  end
               end
               pfmc_pkg::MODE_EVICT: begin
                  cmd.ld   = pfmc_pkg::LD_HAND;
                  state_in = S_ESCAN1;
               end
               default: begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = pfmc_pkg::STAT_OK;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_INIT: begin
            cmd.wr = pfmc_pkg::WR_INIT;
            if (stat.wr_last) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_OK;
               state_in       = S_IDLE;
            end
         end
         S_ASCAN: begin
            cmd.cnt_upd = stat.pv;
            if (stat.pv && stat.cnt_hit) begin
               cmd.ld   = pfmc_pkg::LD_ALLOC_WR;
               state_in = S_AWRITE;
            end else if (!stat.pv && !stat.idx_more) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_NO_SPACE;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         S_AWRITE: begin
            cmd.wr = pfmc_pkg::WR_ALLOC;
            if (stat.wr_last) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_OK;
               cmd.rsp_sel    = pfmc_pkg::RS_START;
               state_in       = S_IDLE;
            end
         end
         S_FHEAD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FRUN;
         end
         S_FRUN: begin
            if (stat.run_bad) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_BAD_FREE;
               cmd.rsp_sel    = pfmc_pkg::RS_FR;
               state_in       = S_IDLE;
            end else begin
               cmd.ld   = pfmc_pkg::LD_RUN;
               state_in = S_FCHECK;
            end
         end
         S_FCHECK: begin
            if (stat.pv && stat.d_free) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_BAD_FREE;
               cmd.rsp_sel    = pfmc_pkg::RS_FR;
               state_in       = S_IDLE;
            end else if (!stat.pv && !stat.idx_more) begin
               cmd.ld   = pfmc_pkg::LD_REWIND;
               state_in = S_FWRITE;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         S_FWRITE: begin
            cmd.wr = pfmc_pkg::WR_FREE;
            if (stat.wr_last) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_OK;
               cmd.rsp_sel    = pfmc_pkg::RS_FR;
               state_in       = S_IDLE;
            end
         end
         S_RREAD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_REVAL;
         end
         S_REVAL: begin
            cmd.rsp_fire = 1'b1;
            cmd.rsp_sel  = pfmc_pkg::RS_FR;
            state_in     = S_IDLE;
            if (!stat.d_user || stat.owner_zero) begin
               cmd.rsp_status = pfmc_pkg::STAT_BAD_REF;
            end else begin
               cmd.rsp_status = pfmc_pkg::STAT_OK;
               cmd.wr         = pfmc_pkg::WR_REF_SET;
            end
         end
         S_ESCAN1, S_ESCAN2: begin
            if (stat.pv && stat.d_user && !stat.d_ref) begin
               cmd.hand_load  = 1'b1;
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = pfmc_pkg::STAT_OK;
               cmd.rsp_sel    = pfmc_pkg::RS_VICTIM;
               state_in       = S_IDLE;
            end else if (!stat.pv && !stat.idx_more) begin
               if (state_ff == S_ESCAN1) begin
                  cmd.ld   = pfmc_pkg::LD_SCAN_F;
                  state_in = S_ESCAN2;
               end else begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = pfmc_pkg::STAT_NO_VICTIM;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               if (stat.pv && stat.d_user) begin
                  cmd.wr = pfmc_pkg::WR_REF_CLR;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   a_rsp_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire |=> state_ff == S_IDLE)
      else $error("response issued without returning to idle");

   a_pass_write_no_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr == pfmc_pkg::WR_INIT || cmd.wr == pfmc_pkg::WR_ALLOC ||
       cmd.wr == pfmc_pkg::WR_FREE || cmd.wr == pfmc_pkg::WR_CLEAR) |-> !cmd.rd_en)
      else $error("pass write overlaps a read");

   a_start_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_DISPATCH)
      else $error("accepted transaction not dispatched");

endmodule

/* dv/page_frame_manager_clock_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame manager checker
// Watches the request, response and register channels, keeps its own frame
// map and clock hand, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module page_frame_manager_clock_checker #(
   parameter int FRAMES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  pfmc_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  pfmc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [pfmc_pkg::CFG_W-1:0]    csr_wdata,
   output int                            failures,
   output int                            pending
);

   logic [1:0]                   map_kind  [FRAMES];
   logic [pfmc_pkg::RUN_W-1:0]   map_run   [FRAMES];
   logic [pfmc_pkg::OWNER_W-1:0] map_owner [FRAMES];
   logic                         map_ref   [FRAMES];
   int                           hand;
   logic [pfmc_pkg::CFG_W-1:0]   first_usable;
   logic [pfmc_pkg::CFG_W-1:0]   frame_limit;
   pfmc_pkg::rsp_type            expected_rsps [$];

   function automatic int limit_eff();
      return (frame_limit < FRAMES) ? int'(frame_limit) : FRAMES;
   endfunction

   function automatic int first_eff();
      int l;
      l = limit_eff();
      return (first_usable < l) ? int'(first_usable) : l;
   endfunction

   // Second-chance walk over [lo, hi); clears reference bits it passes.
   function automatic int clock_walk(int lo, int hi);
      for (int i = lo; i < hi; i++) begin
         if (map_kind[i] == pfmc_pkg::KIND_USER) begin
            if (!map_ref[i]) return i;
            map_ref[i] = 1'b0;
         end
      end
      return -1;
   endfunction

   function automatic pfmc_pkg::rsp_type predict_frame_op(pfmc_pkg::req_type rq);
      pfmc_pkg::rsp_type r;
      int l, f, cnt, head, run, n, fr, v;
      bit ok;
      l = limit_eff();
      f = first_eff();
      n = rq.page_count;
      fr = rq.frame;
      r = '0;
      case (rq.mode)
         pfmc_pkg::MODE_INIT: begin
            for (int i = 0; i < FRAMES; i++) begin
               map_kind[i]  = (i < f) ? pfmc_pkg::KIND_KERN : pfmc_pkg::KIND_FREE;
               map_run[i]   = pfmc_pkg::RUN_W'(1);
               map_owner[i] = '0;
               map_ref[i]   = (i < f);
            end
            hand = 0;
         end
         pfmc_pkg::MODE_ALLOC: begin
            head = -1;
            cnt = 0;
            if (n != 0) begin
               for (int i = f; i < l && head < 0; i++) begin
                  cnt = (map_kind[i] == pfmc_pkg::KIND_FREE) ? cnt + 1 : 0;
                  if (cnt == n) head = i + 1 - n;
               end
            end
            if (head < 0) begin
               r.status = pfmc_pkg::STAT_NO_SPACE;
            end else begin
               for (int i = head; i < head + n; i++) begin
                  map_kind[i]  = rq.kernel_alloc ? pfmc_pkg::KIND_KERN : pfmc_pkg::KIND_USER;
                  map_owner[i] = rq.kernel_alloc ? '0 : rq.owner_tag;
                  map_run[i]   = (i == head) ? pfmc_pkg::RUN_W'(n) : '0;
               end
               r.status = pfmc_pkg::STAT_OK;
               r.result_frame = pfmc_pkg::FRAME_W'(head);
            end
         end
         pfmc_pkg::MODE_FREE: begin
            ok = (fr >= f) && (fr < l);
            run = 0;
            if (ok) begin
               run = map_run[fr];
               if (run == 0 || run > l - fr) ok = 0;
            end
            if (ok) begin
               for (int i = fr; i < fr + run; i++)
                  if (map_kind[i] == pfmc_pkg::KIND_FREE) ok = 0;
            end
            if (ok) begin
               for (int i = fr; i < fr + run; i++) begin
                  map_kind[i]  = pfmc_pkg::KIND_FREE;
                  map_run[i]   = '0;
                  map_owner[i] = '0;
                  map_ref[i]   = 1'b1;
               end
            end
            r.status = ok ? pfmc_pkg::STAT_OK : pfmc_pkg::STAT_BAD_FREE;
            r.result_frame = rq.frame;
         end
         pfmc_pkg::MODE_REF: begin
            if (fr >= l || map_kind[fr] != pfmc_pkg::KIND_USER || map_owner[fr] == '0) begin
               r.status = pfmc_pkg::STAT_BAD_REF;
            end else begin
               map_ref[fr] = 1'b1;
               r.status = pfmc_pkg::STAT_OK;
            end
            r.result_frame = rq.frame;
         end
         pfmc_pkg::MODE_EVICT: begin
            v = clock_walk(hand + 1, l);
            if (v < 0) v = clock_walk(f, l);
            if (v < 0) begin
               r.status = pfmc_pkg::STAT_NO_VICTIM;
            end else begin
               hand = v;
               r.status = pfmc_pkg::STAT_OK;
               r.result_frame = pfmc_pkg::FRAME_W'(v);
               r.result_owner = map_owner[v];
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      pfmc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            map_kind[i]  = pfmc_pkg::KIND_FREE;
            map_run[i]   = pfmc_pkg::RUN_W'(1);
            map_owner[i] = '0;
            map_ref[i]   = 1'b0;
         end
         hand = 0;
         first_usable = '0;
         frame_limit = pfmc_pkg::CFG_W'(1024);
         expected_rsps.delete();
         failures = 0;
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("ERROR: response with nothing expected: %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.result_frame !== want.result_frame ||
                   rsp_data.result_owner !== want.result_owner) begin
                  failures++;
                  if (failures <= 10)
                     $display("ERROR: expected st=%0d fr=%0d ow=%h, got st=%0d fr=%0d ow=%h",
                              want.status, want.result_frame, want.result_owner,
                              rsp_data.status, rsp_data.result_frame,
                              rsp_data.result_owner);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == pfmc_pkg::CSR_FIRST_USABLE) first_usable = csr_wdata;
            else frame_limit = csr_wdata;
         end
         if (start && !busy)
            expected_rsps.push_back(predict_frame_op(req_data));
         pending = expected_rsps.size();
      end
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame manager testbench
// Drives directed and random frame map transactions under several frame
// window settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAMES = 1024;
   // Slowest transaction is an evict, which may walk the map twice; allow for
   // that on every transaction plus gaps, the clearing pass and margin.
   localparam int CYCLE_LIMIT = 4000000;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   pfmc_pkg::req_type          req_data;
   logic                       rsp_valid;
   pfmc_pkg::rsp_type          rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_index;
   logic [pfmc_pkg::CFG_W-1:0] csr_wdata;
   int                         failures;
   int                         pending;
   int                         cycles = 0;
   int                         sent;
   int                         settings_run;
   int                         cur_first;
   int                         cur_limit;

   page_frame_manager_clock_unit #(.FRAMES(FRAMES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   page_frame_manager_clock_checker #(.FRAMES(FRAMES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .failures(failures), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Presents one transaction and holds it until the block takes it. The
   // caller is at a falling edge; start is left high so that a following
   // transaction can go out back to back without lowering it.
   task automatic issue_request(pfmc_pkg::req_type rq);
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
   endtask

   task automatic maybe_idle(bit quiet);
      int gap;
      if (!quiet && $urandom_range(0, 99) < 30) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits for every response to come back; registers only change when the
   // block is idle.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_reg(logic idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= pfmc_pkg::CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Sets the frame window, then re-initializes the map under it.
   task automatic set_window(int first_val, int limit_val);
      pfmc_pkg::req_type rq;
      drain();
      write_reg(pfmc_pkg::CSR_FIRST_USABLE, first_val);
      write_reg(pfmc_pkg::CSR_FRAME_LIMIT, limit_val);
      csr_valid <= 1'b0;
      cur_limit = (limit_val < FRAMES) ? limit_val : FRAMES;
      cur_first = (first_val < cur_limit) ? first_val : cur_limit;
      settings_run++;
      rq = '0;
      rq.mode = pfmc_pkg::MODE_INIT;
      issue_request(rq);
   endtask

   function automatic pfmc_pkg::req_type mk(logic [2:0] m, int n, bit k, logic [31:0] tag,
                                            int fr);
      pfmc_pkg::req_type rq;
      rq.mode = m;
      rq.page_count = pfmc_pkg::RUN_W'(n);
      rq.kernel_alloc = k;
      rq.owner_tag = tag;
      rq.frame = pfmc_pkg::FRAME_W'(fr);
      return rq;
   endfunction

   // Random transaction biased toward the managed window so that frees and
   // references land on real run heads often enough to succeed.
   function automatic pfmc_pkg::req_type random_request();
      pfmc_pkg::req_type rq;
      int pick;
      rq.owner_tag = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom);
      rq.kernel_alloc = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 32) rq.mode = pfmc_pkg::MODE_ALLOC;
      else if (pick < 56) rq.mode = pfmc_pkg::MODE_FREE;
      else if (pick < 72) rq.mode = pfmc_pkg::MODE_REF;
      else if (pick < 93) rq.mode = pfmc_pkg::MODE_EVICT;
      else if (pick < 96) rq.mode = pfmc_pkg::MODE_INIT;
      else rq.mode = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70) rq.page_count = pfmc_pkg::RUN_W'($urandom_range(1, 4));
      else if (pick < 85) rq.page_count = pfmc_pkg::RUN_W'($urandom_range(1, cur_limit + 1));
      else if (pick < 90) rq.page_count = '0;
      else rq.page_count = pfmc_pkg::RUN_W'($urandom);
      if (cur_limit > cur_first && $urandom_range(0, 99) < 85)
         rq.frame = pfmc_pkg::FRAME_W'($urandom_range(cur_first, cur_limit - 1));
      else
         rq.frame = pfmc_pkg::FRAME_W'($urandom);
      return rq;
   endfunction

   task automatic random_phase(int first_val, int limit_val, int count, bit quiet);
      set_window(first_val, limit_val);
      for (int i = 0; i < count; i++) begin
         maybe_idle(quiet);
         issue_request(random_request());
      end
   endtask

   initial begin
      pfmc_pkg::req_type directed [$];
      int waited;
      sent = 0;
      settings_run = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset window: the whole map is managed.
      cur_first = 0;
      cur_limit = FRAMES;
      directed = '{
         mk(pfmc_pkg::MODE_EVICT, 1, 0, 0, 0),     // evict with no user frames
         mk(pfmc_pkg::MODE_INIT, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_ALLOC, 0, 0, 1, 0),     // zero count is no space
         mk(pfmc_pkg::MODE_ALLOC, 1, 0, 32'hFFFF_FFFF, 0),
         mk(pfmc_pkg::MODE_ALLOC, 3, 1, 32'h1234, 0), // kernel run drops the owner
         mk(pfmc_pkg::MODE_REF, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_REF, 1, 0, 0, 1),       // kernel frame is a bad reference
         mk(pfmc_pkg::MODE_REF, 1, 0, 0, 1023),    // free frame is a bad reference
         mk(pfmc_pkg::MODE_EVICT, 1, 0, 0, 0),     // second chance clears the bit
         mk(pfmc_pkg::MODE_EVICT, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 0),      // double free
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 2),      // not a run head
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 1),
         mk(pfmc_pkg::MODE_ALLOC, 1024, 0, 32'h5A5A_0001, 0), // run ends at the last frame
         mk(pfmc_pkg::MODE_ALLOC, 2047, 0, 1, 0),  // oversized count
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 0),      // free reaching exactly the limit
         mk(pfmc_pkg::MODE_FREE, 1, 0, 0, 1023),
         mk(3'd5, 1, 0, 0, 0),
         mk(3'd6, 2047, 1, 32'hFFFF_FFFF, 1023),
         mk(3'd7, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_ALLOC, 2, 0, 0, 0),     // user frames with no owner
         mk(pfmc_pkg::MODE_REF, 1, 0, 0, 0),
         mk(pfmc_pkg::MODE_EVICT, 1, 0, 0, 0)
      };
      foreach (directed[i]) issue_request(directed[i]);

      // Random part: mostly small windows keep walks short; a few phases
      // cover the full map, an empty window and a first frame past the limit.
      random_phase(3, 12, 90, 0);
      random_phase(0, 1, 25, 0);
      random_phase(8, 8, 15, 0);
      random_phase(1500, 40, 15, 0);
      random_phase(0, 2047, 40, 0);
      random_phase(1024, 1024, 15, 0);
      random_phase(5, 33, 120, 0);
      random_phase(1, 1000, 30, 0);
      random_phase(0, 20, 160, 0);
      random_phase(2, 24, 70, 1);       // closing stretch with no idling

      start <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 3 * FRAMES) begin
         @(negedge clock);
         waited++;
      end
      repeat (2 * FRAMES + 16) @(negedge clock);

      $display("Sent %0d transactions across %0d frame window settings,", sent, settings_run);
      $display("covering every mode, unused modes and the window extremes.");
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/pfmc_pkg.sv
rtl/pfmc_datapath.sv
rtl/pfmc_controller.sv
rtl/page_frame_manager_clock_unit.sv
dv/page_frame_manager_clock_checker.sv
dv/testbench.sv
